// ===== hdl/tlc_pkg.sv =====
// Shared types, codes and helpers for the tree leaf counter.
// No dependencies; tlc_path and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

  // Fixed field widths of the stream payloads.
  localparam int ACTION_W = 2;
  localparam int NODE_W   = 7;
  localparam int LEVEL_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_CAP = 7'd127;

  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_WINIT,
    S_SCAN,
    S_NODE,
    S_KIDS,
    S_LVL_END,
    S_ERD,
    S_EOUT
  } state_t;

  // Level-wide commands from the sequencer to the path-count unit.
  typedef struct packed {
    logic init;  // start a walk: root holds one path, everything else none
    logic swap;  // move to the next level
  } path_cmd_t;

  // Count addition that sticks at the cap.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_CAP : s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tlc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// A read of the address written in the same cycle returns the old contents.
`timescale 1ns / 1ps
`default_nettype none

module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/tlc_path.sv =====
// Per-node path counts of the level walk: two banks (current and next level),
// each a tlc_ram with valid bits, plus the read-modify-write stage for children.
// Depends on tlc_pkg and tlc_ram.
`timescale 1ns / 1ps
`default_nettype none

module tlc_path
  import tlc_pkg::*;
#(
  parameter int MAX_NODES = 64,
  localparam int NW = $clog2(MAX_NODES)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire path_cmd_t          cmd,
  input  wire logic [NW-1:0]      scan_idx,
  input  wire logic               kid_valid,
  input  wire logic [NW-1:0]      kid_idx,
  input  wire logic [COUNT_W-1:0] parent_paths,
  output logic      [COUNT_W-1:0] scan_paths,
  output logic                    busy,
  output logic                    any_next
);

  logic                 cur_r;
  logic                 nb;
  logic [MAX_NODES-1:0] valid_r [2];
  logic [MAX_NODES-1:0] valid_nxt [2];
  logic [NW-1:0]        scan_idx_r;
  logic                 sc_valid_r;
  logic [NW-1:0]        sc_addr_r;
  logic                 fwd_valid_r;
  logic [NW-1:0]        fwd_addr_r;
  logic [COUNT_W-1:0]   fwd_data_r;
  logic                 any_r;
  logic                 any_nxt;

  logic [NW-1:0]        ram_ra [2];
  logic [NW-1:0]        ram_wa [2];
  logic                 ram_we [2];
  logic [COUNT_W-1:0]   ram_wd [2];
  logic [COUNT_W-1:0]   ram_rd [2];

  logic [COUNT_W-1:0]   old_raw;
  logic [COUNT_W-1:0]   old_val;
  logic [COUNT_W-1:0]   sum;

  assign nb = ~cur_r;

  // A write made in the same cycle as the read address is not in the RAM data yet.
  always_comb begin
    old_raw = valid_r[nb][sc_addr_r] ? ram_rd[nb] : '0;
    old_val = (fwd_valid_r && (fwd_addr_r == sc_addr_r)) ? fwd_data_r : old_raw;
    sum     = sat_add(old_val, parent_paths);
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      ram_ra[b] = (1'(b) == cur_r) ? scan_idx : kid_idx;
      if (cmd.init) begin
        ram_we[b] = (b == 0);
        ram_wa[b] = '0;
        ram_wd[b] = COUNT_W'(1);
      end else begin
        ram_we[b] = (1'(b) != cur_r) && sc_valid_r;
        ram_wa[b] = sc_addr_r;
        ram_wd[b] = sum;
      end
    end
  end

  always_comb begin
    valid_nxt[0] = valid_r[0];
    valid_nxt[1] = valid_r[1];
    any_nxt      = any_r;
    if (cmd.init) begin
      valid_nxt[0] = MAX_NODES'(1);
      valid_nxt[1] = '0;
      any_nxt      = 1'b0;
    end else if (cmd.swap) begin
      valid_nxt[cur_r] = '0;
      any_nxt          = 1'b0;
    end else if (sc_valid_r) begin
      valid_nxt[nb][sc_addr_r] = 1'b1;
      any_nxt                  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= 1'b0;
      valid_r[0]  <= '0;
      valid_r[1]  <= '0;
      sc_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      if (cmd.init) begin
        cur_r <= 1'b0;
      end else if (cmd.swap) begin
        cur_r <= ~cur_r;
      end
      valid_r[0]  <= valid_nxt[0];
      valid_r[1]  <= valid_nxt[1];
      sc_valid_r  <= kid_valid;
      fwd_valid_r <= sc_valid_r;
      any_r       <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx;
    sc_addr_r  <= kid_idx;
    fwd_addr_r <= sc_addr_r;
    fwd_data_r <= sum;
  end

  tlc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_bank0 (
    .clk  (clk),
    .we   (ram_we[0]),
    .waddr(ram_wa[0]),
    .wdata(ram_wd[0]),
    .raddr(ram_ra[0]),
    .rdata(ram_rd[0])
  );

  tlc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_bank1 (
    .clk  (clk),
    .we   (ram_we[1]),
    .waddr(ram_wa[1]),
    .wdata(ram_wd[1]),
    .raddr(ram_ra[1]),
    .rdata(ram_rd[1])
  );

  assign scan_paths = valid_r[cur_r][scan_idx_r] ? ram_rd[cur_r] : '0;
  assign busy       = sc_valid_r;
  assign any_next   = any_r;

endmodule

`default_nettype wire

// ===== hdl/tree_leaf_count_per_level.sv =====
// Top level of the tree leaf counter: sequencer, child count/table memories,
// per-level leaf memory and output register. Depends on tlc_pkg, tlc_ram, tlc_path.
//
// Channel  Dir  Handshake            Payload
// in_      in   tvalid/tready        tdata: action, parent_node, child_node
// out_     out  tvalid/tready/tlast  tdata: level, leaf_count; tlast: last
//
// A begin or unused action is done at its transfer; an add reads the child count, then writes.
// A count goes through transfer and walk setup, then per level walked a scan and a node
// step for each node, a child loop for each node expanded and a level close; then a
// read and an output step per emitted level, waiting while the output register is full.
// Reset clears the control state and the child-count valid bits; there is no
// memory clearing pass. The output register holds a result until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module tree_leaf_count_per_level
  import tlc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,   // action[1:0], parent_node[8:2], child_node[15:9]
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // level[5:0], leaf_count[12:6], zero[15:13]
  output logic                 out_tlast
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = NW + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  state_t state_r, state_nxt;

  logic [ACTION_W-1:0] in_action;
  logic [NODE_W-1:0]   in_parent;
  logic [NODE_W-1:0]   in_child;
  logic [NW-1:0]       in_pidx;
  logic [NW-1:0]       in_cidx;
  logic                in_fire;

  logic                 add_ok_r, add_ok_nxt;
  logic [NW-1:0]        add_pidx_r, add_pidx_nxt;
  logic [NW-1:0]        add_cidx_r, add_cidx_nxt;
  logic [MAX_NODES-1:0] cvalid_r, cvalid_nxt;
  logic [NW-1:0]        d_r, d_nxt;
  logic [NW-1:0]        v_r, v_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   p_r, p_nxt;
  logic [COUNT_W-1:0]   acc_r, acc_nxt;
  logic [NW-1:0]        deepest_r, deepest_nxt;
  logic [NW-1:0]        e_r, e_nxt;
  logic                 sb_valid_r, sb_valid_nxt;

  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_last_r;
  logic                 out_load;
  logic                 out_free;

  logic [NW-1:0]        cc_ra;
  logic                 cc_we;
  logic [CW-1:0]        cc_wd;
  logic [CW-1:0]        cc_rd;
  logic [CW-1:0]        cnt_add;
  logic [CW-1:0]        cnt_node;
  logic [NW-1:0]        ct_rd;
  logic                 lv_we;
  logic [COUNT_W-1:0]   lv_rd;

  path_cmd_t            path_cmd;
  logic [COUNT_W-1:0]   node_paths;
  logic                 path_busy;
  logic                 path_any;

  logic                 issue_kid;
  logic                 kids_done;
  logic                 go_kids;
  logic                 last_node;
  logic                 last_level;

  assign in_action = in_tdata[1:0];
  assign in_parent = in_tdata[8:2];
  assign in_child  = in_tdata[15:9];
  assign in_pidx   = NW'(in_parent - 7'd1);
  assign in_cidx   = NW'(in_child - 7'd1);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign cnt_add  = cvalid_r[add_pidx_r] ? cc_rd : '0;
  assign cnt_node = cvalid_r[v_r] ? cc_rd : '0;
  assign cc_ra    = (state_r == S_IDLE) ? in_pidx : v_r;
  assign cc_we    = (state_r == S_ADD) && add_ok_r && (cnt_add < CW'(MAX_NODES));
  assign cc_wd    = cnt_add + CW'(1);
  assign lv_we    = (state_r == S_LVL_END);

  assign last_node  = (v_r == LAST_NODE);
  assign last_level = (d_r == LAST_NODE);
  assign issue_kid  = (state_r == S_KIDS) && (k_r < cnt_r);
  assign kids_done  = (state_r == S_KIDS) && (k_r == cnt_r) && !sb_valid_r && !path_busy;
  assign go_kids    = (node_paths != '0) && (cnt_node != '0) && !last_level;
  assign out_free   = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_ADD) begin
            state_nxt = S_ADD;
          end else if (in_action == ACT_COUNT) begin
            state_nxt = S_WINIT;
          end
        end
      end
      S_ADD:   state_nxt = S_IDLE;
      S_WINIT: state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_NODE;
      S_NODE: begin
        if (go_kids) begin
          state_nxt = S_KIDS;
        end else begin
          state_nxt = last_node ? S_LVL_END : S_SCAN;
        end
      end
      S_KIDS: begin
        if (kids_done) begin
          state_nxt = last_node ? S_LVL_END : S_SCAN;
        end
      end
      S_LVL_END: begin
        state_nxt = (path_any && !last_level) ? S_SCAN : S_ERD;
      end
      S_ERD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_free) begin
          state_nxt = (e_r == deepest_r) ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    add_ok_nxt   = add_ok_r;
    add_pidx_nxt = add_pidx_r;
    add_cidx_nxt = add_cidx_r;
    cvalid_nxt   = cvalid_r;
    d_nxt        = d_r;
    v_nxt        = v_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    p_nxt        = p_r;
    acc_nxt      = acc_r;
    deepest_nxt  = deepest_r;
    e_nxt        = e_r;
    sb_valid_nxt = issue_kid;
    path_cmd     = '0;
    out_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_BEGIN) begin
            cvalid_nxt = '0;
          end
          add_ok_nxt   = (in_parent != '0) && (in_parent <= NODE_W'(MAX_NODES)) &&
                         (in_child != '0) && (in_child <= NODE_W'(MAX_NODES));
          add_pidx_nxt = in_pidx;
          add_cidx_nxt = in_cidx;
        end
      end
      S_ADD: begin
        if (cc_we) begin
          cvalid_nxt[add_pidx_r] = 1'b1;
        end
      end
      S_WINIT: begin
        d_nxt         = '0;
        v_nxt         = '0;
        acc_nxt       = '0;
        deepest_nxt   = '0;
        path_cmd.init = 1'b1;
      end
      S_NODE: begin
        if (go_kids) begin
          p_nxt   = node_paths;
          cnt_nxt = cnt_node;
          k_nxt   = '0;
        end else begin
          if ((node_paths != '0) && (cnt_node == '0)) begin
            acc_nxt     = sat_add(acc_r, node_paths);
            deepest_nxt = d_r;
          end
          if (!last_node) begin
            v_nxt = v_r + NW'(1);
          end
        end
      end
      S_KIDS: begin
        if (issue_kid) begin
          k_nxt = k_r + CW'(1);
        end
        if (kids_done && !last_node) begin
          v_nxt = v_r + NW'(1);
        end
      end
      S_LVL_END: begin
        if (path_any && !last_level) begin
          d_nxt         = d_r + NW'(1);
          v_nxt         = '0;
          acc_nxt       = '0;
          path_cmd.swap = 1'b1;
        end else begin
          e_nxt = '0;
        end
      end
      S_EOUT: begin
        out_load = out_free;
        if (out_free && (e_r != deepest_r)) begin
          e_nxt = e_r + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cvalid_r    <= '0;
      sb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cvalid_r    <= cvalid_nxt;
      sb_valid_r  <= sb_valid_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    add_ok_r   <= add_ok_nxt;
    add_pidx_r <= add_pidx_nxt;
    add_cidx_r <= add_cidx_nxt;
    d_r        <= d_nxt;
    v_r        <= v_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    deepest_r  <= deepest_nxt;
    e_r        <= e_nxt;
    if (out_load) begin
      out_level_r <= LEVEL_W'(e_r);
      out_cnt_r   <= lv_rd;
      out_last_r  <= (e_r == deepest_r);
    end
  end

  tlc_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_child_count (
    .clk  (clk),
    .we   (cc_we),
    .waddr(add_pidx_r),
    .wdata(cc_wd),
    .raddr(cc_ra),
    .rdata(cc_rd)
  );

  // Child lists: row per parent, column per list slot.
  tlc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES << NW)) u_child_table (
    .clk  (clk),
    .we   (cc_we),
    .waddr({add_pidx_r, cnt_add[NW-1:0]}),
    .wdata(add_cidx_r),
    .raddr({v_r, k_r[NW-1:0]}),
    .rdata(ct_rd)
  );

  tlc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_leaves (
    .clk  (clk),
    .we   (lv_we),
    .waddr(d_r),
    .wdata(acc_r),
    .raddr(e_r),
    .rdata(lv_rd)
  );

  tlc_path #(.MAX_NODES(MAX_NODES)) u_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (path_cmd),
    .scan_idx    (v_r),
    .kid_valid   (sb_valid_r),
    .kid_idx     (ct_rd),
    .parent_paths(p_r),
    .scan_paths  (node_paths),
    .busy        (path_busy),
    .any_next    (path_any)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_level_r};
  assign out_tlast  = out_last_r;

  // The child update pipeline must be empty before a level is closed.
  a_level_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LVL_END) |-> (!sb_valid_r && !path_busy))
    else $error("level closed with child updates in flight");

  a_kid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KIDS) |-> (k_r <= cnt_r))
    else $error("child slot index ran past the child count");

  a_kid_origin: assert property (@(posedge clk) disable iff (!rst_n)
    sb_valid_r |-> ($past(state_r) == S_KIDS))
    else $error("child table data marked valid outside the child loop");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> !$past(out_load))
    else $error("output register loaded over an untaken result");

endmodule

`default_nettype wire
